// ===== src/b36ce_pkg.sv =====
// ----------------------------------------------------------------------------
// b36ce_pkg: shared types, constants and functions of the base-36 encoder
// Holds the chunk descriptor, the converter states, the reciprocal
// constants used for division by constants and the symbol tables.
// ----------------------------------------------------------------------------
package b36ce_pkg;

  localparam logic [2:0] BYTES_PER_CHUNK = 3'd5;
  localparam logic [3:0] CHUNK_CHARS     = 4'd8;
  localparam logic [7:0] PAD_CHAR        = 8'h3D;

  // 36^4 splits a chunk value into two halves of four digits each.
  localparam logic [20:0] B36_POW4 = 21'd1679616;

  // floor(x / 6561) for a 32-bit x, with 36^4 = 256 * 6561.
  localparam int          H_SHIFT      = 45;
  localparam logic [63:0] H_RECIP_FULL = ((64'd1 << 45) + 64'd6560) / 64'd6561;
  localparam logic [32:0] H_RECIP      = H_RECIP_FULL[32:0];

  // floor(x / 36) for a 21-bit x.
  localparam int          D36_SHIFT      = 27;
  localparam logic [63:0] D36_RECIP_FULL = ((64'd1 << 27) + 64'd35) / 64'd36;
  localparam logic [21:0] D36_RECIP      = D36_RECIP_FULL[21:0];

  typedef struct packed {
    logic [39:0] value;
    logic [2:0]  nbytes;
    logic        eom;
  } chunk_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DIVH,
    C_SUBL,
    C_DIGIT,
    C_DONE
  } conv_state_t;

  function automatic logic [20:0] div36(input logic [20:0] x);
    logic [42:0] prod;
    prod = 43'(x) * 43'(D36_RECIP);
    return 21'(prod >> D36_SHIFT);
  endfunction

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    if (d < 6'd10) begin
      c = 8'h30 + 8'(d);
    end else begin
      c = 8'h37 + 8'(d);
    end
    return c;
  endfunction

  function automatic logic [3:0] digit_count(input logic [2:0] nb);
    logic [3:0] nd;
    unique case (nb)
      3'd1:    nd = 4'd2;
      3'd2:    nd = 4'd4;
      3'd3:    nd = 4'd5;
      3'd4:    nd = 4'd7;
      3'd5:    nd = 4'd8;
      default: nd = 4'd0;
    endcase
    return nd;
  endfunction

endpackage

// ===== src/b36ce_ifs.sv =====
// ----------------------------------------------------------------------------
// b36ce_ifs: byte and symbol channels of the base-36 encoder
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface b36ce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b36ce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       chunk_last;
  logic       message_last;

  modport source (output valid, output symbol, output chunk_last, output message_last,
                  input ready);
  modport sink   (input valid, input symbol, input chunk_last, input message_last,
                  output ready);
endinterface

// ===== src/b36ce_fifo.sv =====
// ----------------------------------------------------------------------------
// b36ce_fifo: chunk queue between the packer and the converter
// Small register queue of closed chunks with a combinational head.
// ----------------------------------------------------------------------------
module b36ce_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b36ce_pkg::chunk_t push_data,
  output logic              full,
  input  logic              pop,
  output b36ce_pkg::chunk_t head,
  output logic              not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b36ce_pkg::chunk_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/b36ce_front.sv =====
// ----------------------------------------------------------------------------
// b36ce_front: byte packer
// Packs bytes big-endian into the open chunk and closes it after five
// bytes or at the end of a message, handing it to the chunk queue.
// ----------------------------------------------------------------------------
module b36ce_front (
  input  logic              clk,
  input  logic              rst_n,
  b36ce_in_if.sink          in_ch,
  output logic              push,
  output b36ce_pkg::chunk_t push_data,
  input  logic              fifo_full
);

  logic [39:0] value_r;
  logic [2:0]  nb_r;
  logic [39:0] value_nxt;
  logic [2:0]  nb_nxt;
  logic        accept;
  logic        close;

  assign in_ch.ready = !fifo_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign value_nxt   = {value_r[31:0], in_ch.data_byte};
  assign nb_nxt      = nb_r + 3'd1;
  assign close       = (nb_nxt == b36ce_pkg::BYTES_PER_CHUNK) || in_ch.end_of_message;
  assign push        = accept && close;

  always_comb begin
    push_data.value  = value_nxt;
    push_data.nbytes = nb_nxt;
    push_data.eom    = in_ch.end_of_message;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      nb_r    <= '0;
    end else if (accept) begin
      if (close) begin
        value_r <= '0;
        nb_r    <= '0;
      end else begin
        value_r <= value_nxt;
        nb_r    <= nb_nxt;
      end
    end
  end

endmodule

// ===== src/b36ce_back.sv =====
// ----------------------------------------------------------------------------
// b36ce_back: base-36 converter and symbol serializer
// Splits a chunk value at 36^4, extracts both four-digit halves one digit per
// cycle, builds the eight symbols and shifts them out one per ready cycle.
// ----------------------------------------------------------------------------
module b36ce_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fifo_valid,
  input  b36ce_pkg::chunk_t head,
  output logic              pop,
  b36ce_out_if.source       out_ch
);

  b36ce_pkg::conv_state_t state_r, state_nxt;

  logic [39:0]      v_r;
  logic [2:0]       nb_r;
  logic             eom_r;
  logic [20:0]      hw_r, lw_r;
  logic [1:0]       step_r;
  logic [3:0][5:0]  hi_dig_r, lo_dig_r;

  logic [7:0][7:0]  chars_r;
  logic [3:0]       ocnt_r;
  logic             oeom_r;

  logic             room;
  logic             load;
  logic [64:0]      hprod;
  logic [40:0]      hback;
  logic [20:0]      hq36, lq36;
  logic [20:0]      hrem, lrem;
  logic [7:0][5:0]  dig_w;
  logic [7:0][7:0]  chars_w;

  assign room = (ocnt_r == 4'd0) || ((ocnt_r == 4'd1) && out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      b36ce_pkg::C_IDLE: begin
        if (fifo_valid) begin
          state_nxt = b36ce_pkg::C_DIVH;
        end
      end
      b36ce_pkg::C_DIVH:  state_nxt = b36ce_pkg::C_SUBL;
      b36ce_pkg::C_SUBL:  state_nxt = b36ce_pkg::C_DIGIT;
      b36ce_pkg::C_DIGIT: begin
        if (step_r == 2'd3) begin
          state_nxt = b36ce_pkg::C_DONE;
        end
      end
      b36ce_pkg::C_DONE: begin
        if (room) begin
          state_nxt = fifo_valid ? b36ce_pkg::C_DIVH : b36ce_pkg::C_IDLE;
        end
      end
      default: state_nxt = b36ce_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    unique case (state_r)
      b36ce_pkg::C_IDLE:  pop = fifo_valid;
      b36ce_pkg::C_DONE: begin
        load = room;
        pop  = room && fifo_valid;
      end
      b36ce_pkg::C_DIVH,
      b36ce_pkg::C_SUBL,
      b36ce_pkg::C_DIGIT: begin
        pop  = 1'b0;
        load = 1'b0;
      end
      default: begin
        pop  = 1'b0;
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b36ce_pkg::C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign hprod = 65'(v_r[39:8]) * 65'(b36ce_pkg::H_RECIP);
  assign hback = 41'(hw_r) * 41'(b36ce_pkg::B36_POW4);
  assign hq36  = b36ce_pkg::div36(hw_r);
  assign lq36  = b36ce_pkg::div36(lw_r);
  assign hrem  = hw_r - (hq36 << 5) - (hq36 << 2);
  assign lrem  = lw_r - (lq36 << 5) - (lq36 << 2);

  always_ff @(posedge clk) begin
    if (pop) begin
      v_r   <= head.value;
      nb_r  <= head.nbytes;
      eom_r <= head.eom;
    end
    unique case (state_r)
      b36ce_pkg::C_DIVH: hw_r <= 21'(hprod >> b36ce_pkg::H_SHIFT);
      b36ce_pkg::C_SUBL: begin
        lw_r   <= 21'(41'(v_r) - hback);
        step_r <= 2'd0;
      end
      b36ce_pkg::C_DIGIT: begin
        hw_r     <= hq36;
        lw_r     <= lq36;
        hi_dig_r <= {6'(hrem), hi_dig_r[3:1]};
        lo_dig_r <= {6'(lrem), lo_dig_r[3:1]};
        step_r   <= step_r + 2'd1;
      end
      b36ce_pkg::C_IDLE,
      b36ce_pkg::C_DONE: begin
        step_r <= step_r;
      end
      default: begin
        step_r <= step_r;
      end
    endcase
  end

  assign dig_w = {hi_dig_r, lo_dig_r};

  always_comb begin
    logic [3:0] ndv;
    logic [2:0] idx;
    ndv = b36ce_pkg::digit_count(nb_r);
    idx = '0;
    for (int p = 0; p < 8; p++) begin
      if (4'(p) < ndv) begin
        idx        = 3'(ndv - 4'(p) - 4'd1);
        chars_w[p] = b36ce_pkg::digit_char(dig_w[idx]);
      end else begin
        chars_w[p] = b36ce_pkg::PAD_CHAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars_r <= chars_w;
      oeom_r  <= eom_r;
    end else if ((ocnt_r != 4'd0) && out_ch.ready) begin
      chars_r <= {8'h00, chars_r[7:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= '0;
    end else if (load) begin
      ocnt_r <= b36ce_pkg::CHUNK_CHARS;
    end else if ((ocnt_r != 4'd0) && out_ch.ready) begin
      ocnt_r <= ocnt_r - 4'd1;
    end
  end

  assign out_ch.valid        = (ocnt_r != 4'd0);
  assign out_ch.symbol       = chars_r[0];
  assign out_ch.chunk_last   = (ocnt_r == 4'd1);
  assign out_ch.message_last = (ocnt_r == 4'd1) && oeom_r;

`ifndef SYNTH
  a_half_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == b36ce_pkg::C_DIGIT) |->
      ((hw_r < b36ce_pkg::B36_POW4) && (lw_r < b36ce_pkg::B36_POW4)))
    else $error("Chunk half out of four-digit range.");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> fifo_valid)
    else $error("Chunk taken from an empty queue.");

  a_chunk_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.chunk_last) |=>
      ((ocnt_r == 4'd0) || (ocnt_r == b36ce_pkg::CHUNK_CHARS)))
    else $error("Symbol buffer reloaded at the wrong time.");
`endif

endmodule

// ===== src/base36_chunk_encoder_top.sv =====
// Throughput: one byte per cycle while the chunk queue has room; symbols leave at
// one per cycle while the output is ready, so the serializer sets the sustained
// byte rate. Conversion of the next chunk overlaps the shifting out.
// Reset is synchronous and active low; it empties the packer, queue and serializer.
// ----------------------------------------------------------------------------
// base36_chunk_encoder_top: base-36 encoder of five-byte chunks
// Packer, chunk queue and converter/serializer joined by valid/ready channels.
// ----------------------------------------------------------------------------
module base36_chunk_encoder_top #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  b36ce_in_if.sink     in_ch,
  b36ce_out_if.source  out_ch
);

  logic              push;
  logic              fifo_full;
  logic              pop;
  logic              fifo_valid;
  b36ce_pkg::chunk_t push_data;
  b36ce_pkg::chunk_t head;

  b36ce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .fifo_full (fifo_full)
  );

  b36ce_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .head      (head),
    .not_empty (fifo_valid)
  );

  b36ce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_valid (fifo_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
